FILE: hw/rtl/v2n_pkg.sv
// Package: shared widths, payload types and pipeline constants for the vector normalizer.
package v2n_pkg;

    localparam int unsigned CompW   = 32;             // input component width
    localparam int unsigned MagW    = 32;             // component magnitude width
    localparam int unsigned SumW    = 64;             // x^2 + y^2 width
    localparam int unsigned LenW    = 32;             // root width
    localparam int unsigned UnitW   = 16;             // Q2.14 output width
    localparam int unsigned UnitSh  = 14;             // Q2.14 scale shift
    localparam int unsigned QW      = UnitSh + 1;     // quotient width (<= 16384)
    localparam int unsigned NumW    = MagW + UnitSh;  // dividend width

    typedef logic [MagW-1:0] mag_t;
    typedef logic [SumW-1:0] sum_t;
    typedef logic [LenW-1:0] len_t;

    // Payload of one input transfer: two signed Q16.16 components.
    typedef struct packed {
        logic signed [CompW-1:0] vec_x;
        logic signed [CompW-1:0] vec_y;
    } vec_in_t;

    // Payload of one result transfer.
    typedef struct packed {
        logic signed [UnitW-1:0] unit_x;
        logic signed [UnitW-1:0] unit_y;
        len_t                    length;
        logic                    zero_vector;
    } unit_out_t;

    // Values passed between sqrt stages and on to the dividers.
    typedef struct packed {
        mag_t       ax;
        mag_t       ay;
        logic       nx;
        logic       ny;
        sum_t       rem;
        len_t       root;
    } sqrt_stage_t;

    // Values passed between divider stages.
    typedef struct packed {
        logic [NumW-1:0] rx;     // partial remainders
        logic [NumW-1:0] ry;
        logic [QW-1:0]   qx;
        logic [QW-1:0]   qy;
        logic            nx;
        logic            ny;
        len_t            len;
    } div_stage_t;

endpackage

FILE: hw/rtl/v2n_stream_if.sv
// Interface: valid/ready stream channel with a generic payload.
interface v2n_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/vector2_normalize.sv
// Top level: pipelined 2D vector magnitude and unit vector.
//
//  channel   dir  payload                                   handshake
//  in_vec    in   vec_x[31:0] s, vec_y[31:0] s              valid/ready
//  out_unit  out  unit_x[15:0] s, unit_y[15:0] s,           valid/ready
//                 length[31:0] u, zero_vector
//
//  Stages: input, square root, dividers, output. Throughput: one vector per
//  cycle while out_unit is not stalled; the stage count is set by the bit-serial
//  square root (one result bit per stage) and the restoring dividers (one
//  quotient bit per stage, both components in parallel).
//  Reset clears only the valid bits; payload registers are not reset.
//  A stall at the output freezes the whole pipeline through a common enable;
//  nothing is lost or repeated, and in_vec.ready is high whenever the last
//  stage is empty or being drained.
module vector2_normalize
    import v2n_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    v2n_stream_if.sink   in_vec,
    v2n_stream_if.source out_unit
);

    localparam int unsigned SqN  = LenW;        // sqrt stages, one root bit each
    localparam int unsigned DvN  = QW;          // divider stages, one quotient bit each
    localparam int unsigned NStg = SqN + DvN + 2;

    // Pipeline advance: hold everything while the result waits.
    logic adv;
    logic [NStg-1:0] vld_reg;
    assign adv          = !vld_reg[NStg-1] || out_unit.ready;
    assign in_vec.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NStg-2:0], in_vec.valid};
        end
    end

    // Stage 0: take absolute values and square them.
    sqrt_stage_t s0_reg;
    sqrt_stage_t s0_next;
    logic signed [CompW-1:0] vx, vy;
    always_comb
    begin
        vx = in_vec.data.vec_x;
        vy = in_vec.data.vec_y;
        s0_next.nx   = vx[CompW-1];
        s0_next.ny   = vy[CompW-1];
        s0_next.ax   = vx[CompW-1] ? mag_t'(-vx) : mag_t'(vx);
        s0_next.ay   = vy[CompW-1] ? mag_t'(-vy) : mag_t'(vy);
        s0_next.rem  = '0;
        s0_next.root = '0;
    end

    // Squares registered separately, then summed into the first sqrt stage.
    sum_t sqx_reg, sqy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg  <= s0_next;
            sqx_reg <= sum_t'(s0_next.ax) * sum_t'(s0_next.ax);
            sqy_reg <= sum_t'(s0_next.ay) * sum_t'(s0_next.ay);
        end
    end

    // Sqrt stages: digit-by-digit, one root bit per stage, MSB first.
    sqrt_stage_t sq_reg [SqN];
    generate
        for (genvar i = 0; i < SqN; i++)
        begin : g_sqrt
            sqrt_stage_t prv, nxt;
            logic [LenW+1:0] trial;
            logic [LenW+1:0] part;
            localparam int unsigned Sh = 2 * (SqN - 1 - i);
            if (i == 0)
            begin : g_first
                always_comb
                begin
                    prv     = s0_reg;
                    prv.rem = sqx_reg + sqy_reg;
                end
            end
            else
            begin : g_rest
                assign prv = sq_reg[i-1];
            end
            always_comb
            begin
                nxt   = prv;
                part  = (LenW+2)'(prv.rem >> Sh);
                trial = {prv.root, 2'b01};
                if (part >= trial)
                begin
                    nxt.rem  = prv.rem - (sum_t'(trial) << Sh);
                    nxt.root = {prv.root[LenW-2:0], 1'b1};
                end
                else
                begin
                    nxt.root = {prv.root[LenW-2:0], 1'b0};
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_reg[i] <= nxt;
                end
            end
        end
    endgenerate

    // Divider stages: restoring division of |c| << 14 by length.
    div_stage_t dv_reg [DvN];
    div_stage_t dv_init;
    always_comb
    begin
        dv_init.rx  = NumW'(sq_reg[SqN-1].ax) << UnitSh;
        dv_init.ry  = NumW'(sq_reg[SqN-1].ay) << UnitSh;
        dv_init.qx  = '0;
        dv_init.qy  = '0;
        dv_init.nx  = sq_reg[SqN-1].nx;
        dv_init.ny  = sq_reg[SqN-1].ny;
        dv_init.len = sq_reg[SqN-1].root;
    end

    generate
        for (genvar j = 0; j < DvN; j++)
        begin : g_div
            div_stage_t prv, nxt;
            logic [NumW+QW-1:0] dsh;
            localparam int unsigned Sh = DvN - 1 - j;
            if (j == 0)
            begin : g_first
                assign prv = dv_init;
            end
            else
            begin : g_rest
                assign prv = dv_reg[j-1];
            end
            always_comb
            begin
                nxt = prv;
                dsh = (NumW+QW)'(prv.len) << Sh;
                if ((NumW+QW)'(prv.rx) >= dsh)
                begin
                    nxt.rx = NumW'((NumW+QW)'(prv.rx) - dsh);
                    nxt.qx = prv.qx | (QW'(1) << Sh);
                end
                if ((NumW+QW)'(prv.ry) >= dsh)
                begin
                    nxt.ry = NumW'((NumW+QW)'(prv.ry) - dsh);
                    nxt.qy = prv.qy | (QW'(1) << Sh);
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_reg[j] <= nxt;
                end
            end
        end
    endgenerate

    // Output stage: apply signs and flag the zero vector.
    logic [UnitW-1:0] ux_reg, uy_reg;
    len_t             len_reg;
    logic             zero_reg;
    div_stage_t       dl;
    logic             zl;
    always_comb
    begin
        dl = dv_reg[DvN-1];
        zl = (dl.len == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg   <= zl ? '0 : (dl.nx ? -UnitW'(dl.qx) : UnitW'(dl.qx));
            uy_reg   <= zl ? '0 : (dl.ny ? -UnitW'(dl.qy) : UnitW'(dl.qy));
            len_reg  <= dl.len;
            zero_reg <= zl;
        end
    end

    assign out_unit.valid            = vld_reg[NStg-1];
    assign out_unit.data.unit_x      = ux_reg;
    assign out_unit.data.unit_y      = uy_reg;
    assign out_unit.data.length      = len_reg;
    assign out_unit.data.zero_vector = zero_reg;

`ifndef SYNTH
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_unit.valid |-> (out_unit.data.zero_vector == (out_unit.data.length == '0)))
        else $error("zero flag disagrees with length");
    a_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_unit.valid && out_unit.data.zero_vector |->
            (out_unit.data.unit_x == '0) && (out_unit.data.unit_y == '0))
        else $error("zero vector with nonzero unit");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
